// ===== hw/rtl/fae_pkg.sv =====
package fae_pkg;

    // Fixed field widths of the instruction and result items.
    localparam int OPC_W       = 4;
    localparam int IMM_W       = 16;
    localparam int DEST_W      = 2;
    localparam int REG_SEL_W   = 4;
    localparam int OUT_W       = 64;
    localparam int OUT_REGS    = 4;
    localparam int MAP_W       = 64;
    localparam int QUEUE_DEPTH = 2;

    // Identity opcode map: entry n holds operation n.
    localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

    // Operations after remapping.
    typedef enum logic [OPC_W-1:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_alu_op;

    // States of the multi-cycle multiply sequence.
    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_DONE
    } t_mul_state;

    // Input item as it arrives on the port.
    typedef struct packed {
        logic [OPC_W-1:0]  raw_opcode;
        logic [IMM_W-1:0]  operand_a;
        logic [IMM_W-1:0]  operand_b;
        logic [DEST_W-1:0] dest_index;
    } t_in_item;

    // Result item: the register file after the instruction.
    typedef struct packed {
        logic [OUT_W-1:0] reg_zero;
        logic [OUT_W-1:0] reg_one;
        logic [OUT_W-1:0] reg_two;
        logic [OUT_W-1:0] reg_three;
    } t_out_item;

    // Decoded instruction held in the queue.
    typedef struct packed {
        t_alu_op              op;
        logic [REG_SEL_W-1:0] a_sel;
        logic [REG_SEL_W-1:0] b_sel;
        logic [REG_SEL_W-1:0] dst_sel;
        logic [IMM_W-1:0]     imm_a;
        logic [IMM_W-1:0]     imm_b;
    } t_uop;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hw/rtl/fae_front.sv =====
module fae_front #(
    parameter int NUM_REGS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fae_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [fae_pkg::MAP_W-1:0] i_cfg_data,
    input  fae_pkg::t_q_stat   i_q_stat,
    output logic               o_push,
    output fae_pkg::t_uop      o_uop
);

    localparam int SEL_W   = fae_pkg::REG_SEL_W;
    localparam int IMM_W   = fae_pkg::IMM_W;
    localparam int SUM_W   = 8;
    localparam int SUM_N   = 1 << SUM_W;

    // Residue of each bit weight 2^i modulo the register count.
    function automatic logic [IMM_W*SEL_W-1:0] build_weights();
        logic [IMM_W*SEL_W-1:0] t;
        int w;
        t = '0;
        w = 1 % NUM_REGS;
        for (int i = 0; i < IMM_W; i++) begin
            t[i*SEL_W +: SEL_W] = SEL_W'(w);
            w = (w * 2) % NUM_REGS;
        end
        return t;
    endfunction

    // Final reduction of a weight sum modulo the register count.
    function automatic logic [SUM_N*SEL_W-1:0] build_mod_tbl();
        logic [SUM_N*SEL_W-1:0] t;
        t = '0;
        for (int i = 0; i < SUM_N; i++) begin
            t[i*SEL_W +: SEL_W] = SEL_W'(i % NUM_REGS);
        end
        return t;
    endfunction

    localparam logic [IMM_W*SEL_W-1:0] WEIGHT_TBL = build_weights();
    localparam logic [SUM_N*SEL_W-1:0] MOD_TBL    = build_mod_tbl();

    // Register index: the operand taken modulo the register count.
    function automatic logic [SEL_W-1:0] reg_sel(logic [IMM_W-1:0] v);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < IMM_W; i++) begin
            if (v[i]) begin
                s = s + SUM_W'(WEIGHT_TBL[i*SEL_W +: SEL_W]);
            end
        end
        return MOD_TBL[s*SEL_W +: SEL_W];
    endfunction

    logic [fae_pkg::MAP_W-1:0] r_map;
    logic [fae_pkg::OPC_W-1:0] w_op_code;

    // Opcode map register, always ready for a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= fae_pkg::MAP_RESET;
        end else if (i_cfg_valid) begin
            r_map <= i_cfg_data;
        end
    end

    // An item is taken whenever the queue has room.
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && o_in_ready;

    // Remap the opcode and reduce the register indices.
    assign w_op_code = r_map[{i_in_item.raw_opcode, 2'b00} +: fae_pkg::OPC_W];

    always_comb begin
        o_uop.op      = fae_pkg::t_alu_op'(w_op_code);
        o_uop.a_sel   = reg_sel(i_in_item.operand_a);
        o_uop.b_sel   = reg_sel(i_in_item.operand_b);
        o_uop.dst_sel = reg_sel(IMM_W'(i_in_item.dest_index));
        o_uop.imm_a   = i_in_item.operand_a;
        o_uop.imm_b   = i_in_item.operand_b;
    end

endmodule

// ===== hw/rtl/fae_queue.sv =====
module fae_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fae_pkg::t_uop     i_push_uop,
    input  logic              i_pop,
    output fae_pkg::t_uop     o_head,
    output fae_pkg::t_q_stat  o_stat
);

    localparam int DEPTH = fae_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fae_pkg::t_uop    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_uop;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== hw/rtl/fae_back.sv =====
module fae_back #(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fae_pkg::t_uop      i_head,
    input  fae_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fae_pkg::t_out_item o_out_item
);

    localparam int RIW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW     = DATA_WIDTH;
    localparam int LO_W   = (DATA_WIDTH + 1) / 2;
    localparam int PROD_W = 2 * LO_W;
    localparam int CMP_W  = (DATA_WIDTH > fae_pkg::IMM_W) ? DATA_WIDTH : fae_pkg::IMM_W;
    localparam int OUT_W  = fae_pkg::OUT_W;

    logic [DW-1:0]         r_regs [NUM_REGS];
    logic [DW-1:0]         n_regs [NUM_REGS];
    fae_pkg::t_mul_state   r_state;
    fae_pkg::t_mul_state   n_state;
    logic [DW-1:0]         r_ma;
    logic [DW-1:0]         r_mb;
    logic [RIW-1:0]        r_mdst;
    logic [DW-1:0]         r_acc;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_out_valid;
    fae_pkg::t_out_item    r_out_item;
    fae_pkg::t_out_item    n_out_item;

    logic                  w_head_valid;
    logic                  w_head_mul;
    logic                  w_out_free;
    logic                  w_issue_alu;
    logic                  w_issue_mul;
    logic                  w_mul_done;
    logic                  w_load;
    logic [DW-1:0]         w_ra;
    logic [DW-1:0]         w_rb;
    logic [DW-1:0]         w_imm_a;
    logic [DW-1:0]         w_imm_b;
    logic [CMP_W-1:0]      w_ra_c;
    logic [CMP_W-1:0]      w_rb_c;
    logic [CMP_W-1:0]      w_ia_c;
    logic [CMP_W-1:0]      w_ib_c;
    logic [DW-1:0]         w_alu_res;
    logic [DW-1:0]         w_mul_res;
    logic [LO_W-1:0]       w_mul_x;
    logic [LO_W-1:0]       w_mul_y;
    logic [PROD_W-1:0]     w_mul_p;
    logic [RIW-1:0]        w_wr_dst;
    logic [DW-1:0]         w_wr_data;
    logic [OUT_W-1:0]      w_view [fae_pkg::OUT_REGS];

    // Operand fetch from the register file.
    assign w_head_valid = !i_q_stat.empty;
    assign w_head_mul   = (i_head.op == fae_pkg::OP_MULR) || (i_head.op == fae_pkg::OP_MULI);
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_ra         = r_regs[i_head.a_sel[RIW-1:0]];
    assign w_rb         = r_regs[i_head.b_sel[RIW-1:0]];
    assign w_imm_a      = DW'(i_head.imm_a);
    assign w_imm_b      = DW'(i_head.imm_b);
    assign w_ra_c       = CMP_W'(w_ra);
    assign w_rb_c       = CMP_W'(w_rb);
    assign w_ia_c       = CMP_W'(i_head.imm_a);
    assign w_ib_c       = CMP_W'(i_head.imm_b);

    // Operations other than multiply; comparisons use the full immediate.
    always_comb begin
        unique case (i_head.op)
            fae_pkg::OP_ADDR: w_alu_res = w_ra + w_rb;
            fae_pkg::OP_ADDI: w_alu_res = w_ra + w_imm_b;
            fae_pkg::OP_MULR: w_alu_res = '0;
            fae_pkg::OP_MULI: w_alu_res = '0;
            fae_pkg::OP_BANR: w_alu_res = w_ra & w_rb;
            fae_pkg::OP_BANI: w_alu_res = w_ra & w_imm_b;
            fae_pkg::OP_BORR: w_alu_res = w_ra | w_rb;
            fae_pkg::OP_BORI: w_alu_res = w_ra | w_imm_b;
            fae_pkg::OP_SETR: w_alu_res = w_ra;
            fae_pkg::OP_SETI: w_alu_res = w_imm_a;
            fae_pkg::OP_GTIR: w_alu_res = DW'(w_ia_c > w_rb_c);
            fae_pkg::OP_GTRI: w_alu_res = DW'(w_ra_c > w_ib_c);
            fae_pkg::OP_GTRR: w_alu_res = DW'(w_ra_c > w_rb_c);
            fae_pkg::OP_EQIR: w_alu_res = DW'(w_ia_c == w_rb_c);
            fae_pkg::OP_EQRI: w_alu_res = DW'(w_ra_c == w_ib_c);
            fae_pkg::OP_EQRR: w_alu_res = DW'(w_ra_c == w_rb_c);
        endcase
    end

    // Next state of the multiply sequencer.
    always_comb begin
        unique case (r_state)
            fae_pkg::MUL_IDLE: n_state = w_issue_mul ? fae_pkg::MUL_LL : fae_pkg::MUL_IDLE;
            fae_pkg::MUL_LL:   n_state = fae_pkg::MUL_LH;
            fae_pkg::MUL_LH:   n_state = fae_pkg::MUL_HL;
            fae_pkg::MUL_HL:   n_state = fae_pkg::MUL_DONE;
            fae_pkg::MUL_DONE: n_state = w_out_free ? fae_pkg::MUL_IDLE : fae_pkg::MUL_DONE;
            default:           n_state = fae_pkg::MUL_IDLE;
        endcase
    end

    // Sequencer outputs: issue, pop, result load and multiplier operands.
    always_comb begin
        w_issue_alu = (r_state == fae_pkg::MUL_IDLE) && w_head_valid && !w_head_mul
                      && w_out_free;
        w_issue_mul = (r_state == fae_pkg::MUL_IDLE) && w_head_valid && w_head_mul;
        w_mul_done  = (r_state == fae_pkg::MUL_DONE) && w_out_free;
        o_pop       = w_issue_alu || w_issue_mul;
        w_load      = w_issue_alu || w_mul_done;
        unique case (r_state)
            fae_pkg::MUL_LL: begin
                w_mul_x = r_ma[LO_W-1:0];
                w_mul_y = r_mb[LO_W-1:0];
            end
            fae_pkg::MUL_LH: begin
                w_mul_x = r_ma[LO_W-1:0];
                w_mul_y = LO_W'(r_mb[DW-1:LO_W]);
            end
            fae_pkg::MUL_HL: begin
                w_mul_x = LO_W'(r_ma[DW-1:LO_W]);
                w_mul_y = r_mb[LO_W-1:0];
            end
            default: begin
                w_mul_x = '0;
                w_mul_y = '0;
            end
        endcase
    end

    // Shared half-width multiplier; cross products land above the low half.
    assign w_mul_p   = w_mul_x * w_mul_y;
    assign w_mul_res = r_acc + (DW'(r_prod) << LO_W);

    always_ff @(posedge i_clk) begin
        if (w_issue_mul) begin
            r_ma   <= w_ra;
            r_mb   <= (i_head.op == fae_pkg::OP_MULR) ? w_rb : w_imm_b;
            r_mdst <= i_head.dst_sel[RIW-1:0];
        end
        if (r_state == fae_pkg::MUL_LL || r_state == fae_pkg::MUL_LH
            || r_state == fae_pkg::MUL_HL) begin
            r_prod <= w_mul_p;
        end
        if (r_state == fae_pkg::MUL_LH) begin
            r_acc <= DW'(r_prod);
        end else if (r_state == fae_pkg::MUL_HL) begin
            r_acc <= w_mul_res;
        end
    end

    // Register file update and the snapshot that goes out with the result.
    assign w_wr_dst  = w_mul_done ? r_mdst : i_head.dst_sel[RIW-1:0];
    assign w_wr_data = w_mul_done ? w_mul_res : w_alu_res;

    always_comb begin
        for (int k = 0; k < NUM_REGS; k++) begin
            n_regs[k] = (w_load && w_wr_dst == RIW'(k)) ? w_wr_data : r_regs[k];
        end
        for (int k = 0; k < fae_pkg::OUT_REGS; k++) begin
            w_view[k] = '0;
        end
        for (int k = 0; k < NUM_REGS && k < fae_pkg::OUT_REGS; k++) begin
            w_view[k] = OUT_W'(n_regs[k]);
        end
        n_out_item.reg_zero  = w_view[0];
        n_out_item.reg_one   = w_view[1];
        n_out_item.reg_two   = w_view[2];
        n_out_item.reg_three = w_view[3];
    end

    // Control state, register file and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fae_pkg::MUL_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_regs[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int k = 0; k < NUM_REGS; k++) begin
                r_regs[k] <= n_regs[k];
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fae_pkg::MUL_IDLE) |-> !o_pop)
        else $error("queue popped while a multiply is in progress");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_mul_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fae_pkg::MUL_LL) |=> (r_state == fae_pkg::MUL_LH))
        else $error("multiply sequence did not advance");

    a_mul_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |=> (r_state == fae_pkg::MUL_IDLE && r_out_valid))
        else $error("finished multiply left no result");
`endif

endmodule

// ===== hw/rtl/four_register_alu_executor.sv =====
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in_item  (fae_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready   o_out_item (fae_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (opcode map, 64 bits)
//
// One instruction per cycle while the output register is free, except multiply, which
// holds the back end in MUL_LL, MUL_LH, MUL_HL and MUL_DONE while one half-width
// multiplier forms three partial products. Issued results load the output register.
// Reset is synchronous: the register file clears to zero and the opcode map to identity.
// Input stalls only when the two-entry queue is full; the queue fills while a waiting
// result or a multiply holds the back end.
module four_register_alu_executor #(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fae_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fae_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [fae_pkg::MAP_W-1:0] i_cfg_data
);

    fae_pkg::t_q_stat w_q_stat;
    fae_pkg::t_uop    w_push_uop;
    fae_pkg::t_uop    w_head;
    logic             w_push;
    logic             w_pop;

    // Front end: accept, remap and reduce register indices.
    fae_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_uop       (w_push_uop)
    );

    // Decoupling queue between the two halves.
    fae_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_uop (w_push_uop),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_q_stat)
    );

    // Back end: register file, ALU, multiplier and output register.
    fae_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sv/four_register_alu_executor_checker.sv =====
`timescale 1ns / 1ps

module four_register_alu_executor_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  fae_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  fae_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [fae_pkg::MAP_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_expected_count
);

    localparam int OUT_W    = fae_pkg::OUT_W;
    localparam int OUT_REGS = fae_pkg::OUT_REGS;
    localparam int IMM_W    = fae_pkg::IMM_W;

    // Shadow copy of the register file and of the opcode map.
    logic [OUT_W-1:0]          gpr [OUT_REGS];
    logic [fae_pkg::MAP_W-1:0] op_table;
    fae_pkg::t_out_item        reg_snapshots [$];
    int                        fail_count = 0;

    string field_names [OUT_REGS] = '{"reg_zero", "reg_one", "reg_two", "reg_three"};

    // Runs one instruction on the shadow registers and returns the register file after it.
    function automatic fae_pkg::t_out_item exec_instruction(fae_pkg::t_in_item instr);
        fae_pkg::t_alu_op   op;
        logic [OUT_W-1:0]   ra;
        logic [OUT_W-1:0]   rb;
        logic [OUT_W-1:0]   imm_a;
        logic [OUT_W-1:0]   imm_b;
        logic [OUT_W-1:0]   res;
        fae_pkg::t_out_item snap;
        op    = fae_pkg::t_alu_op'(op_table[4*instr.raw_opcode +: 4]);
        ra    = gpr[instr.operand_a[1:0]];
        rb    = gpr[instr.operand_b[1:0]];
        imm_a = {{(OUT_W-IMM_W){1'b0}}, instr.operand_a};
        imm_b = {{(OUT_W-IMM_W){1'b0}}, instr.operand_b};
        case (op)
            fae_pkg::OP_ADDR: res = ra + rb;
            fae_pkg::OP_ADDI: res = ra + imm_b;
            fae_pkg::OP_MULR: res = ra * rb;
            fae_pkg::OP_MULI: res = ra * imm_b;
            fae_pkg::OP_BANR: res = ra & rb;
            fae_pkg::OP_BANI: res = ra & imm_b;
            fae_pkg::OP_BORR: res = ra | rb;
            fae_pkg::OP_BORI: res = ra | imm_b;
            fae_pkg::OP_SETR: res = ra;
            fae_pkg::OP_SETI: res = imm_a;
            fae_pkg::OP_GTIR: res = (imm_a > rb) ? 64'd1 : 64'd0;
            fae_pkg::OP_GTRI: res = (ra > imm_b) ? 64'd1 : 64'd0;
            fae_pkg::OP_GTRR: res = (ra > rb) ? 64'd1 : 64'd0;
            fae_pkg::OP_EQIR: res = (imm_a == rb) ? 64'd1 : 64'd0;
            fae_pkg::OP_EQRI: res = (ra == imm_b) ? 64'd1 : 64'd0;
            default:          res = (ra == rb) ? 64'd1 : 64'd0;
        endcase
        gpr[instr.dest_index] = res;
        snap.reg_zero  = gpr[0];
        snap.reg_one   = gpr[1];
        snap.reg_two   = gpr[2];
        snap.reg_three = gpr[3];
        return snap;
    endfunction

    // Watch all three channels at each rising edge; signals are sampled before they change.
    always @(posedge i_clk) begin
        fae_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < OUT_REGS; k++) gpr[k] = '0;
            op_table = fae_pkg::MAP_RESET;
            reg_snapshots.delete();
        end else begin
            // An item taken at the same edge as a map write still uses the old map.
            if (i_in_valid && i_in_ready) begin
                reg_snapshots.push_back(exec_instruction(i_in_item));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                op_table = i_cfg_data;
            end
            // Compare each result item with the oldest expectation.
            if (i_out_valid && i_out_ready) begin
                if (reg_snapshots.size() == 0) begin
                    $display("%0t: result item with nothing expected, actual %h",
                             $time, i_out_item);
                    fail_count++;
                end else begin
                    want = reg_snapshots.pop_front();
                    for (int k = 0; k < OUT_REGS; k++) begin
                        if (i_out_item[(OUT_REGS-1-k)*OUT_W +: OUT_W] !==
                            want[(OUT_REGS-1-k)*OUT_W +: OUT_W]) begin
                            $display("%0t: %s expected %h actual %h", $time, field_names[k],
                                     want[(OUT_REGS-1-k)*OUT_W +: OUT_W],
                                     i_out_item[(OUT_REGS-1-k)*OUT_W +: OUT_W]);
                            fail_count++;
                        end
                    end
                end
            end
        end
        o_expected_count <= reg_snapshots.size();
        o_fail_count     <= fail_count;
    end

endmodule

// ===== tb/sv/four_register_alu_executor_tb.sv =====
`timescale 1ns / 1ps

module four_register_alu_executor_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_WAIT  = 10;
    localparam int IMM_W        = fae_pkg::IMM_W;
    localparam int OPC_W        = fae_pkg::OPC_W;
    localparam int DEST_W       = fae_pkg::DEST_W;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    fae_pkg::t_in_item         in_item;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    fae_pkg::t_out_item        out_item;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [fae_pkg::MAP_W-1:0] cfg_data;
    int                        fail_count;
    int                        expected_count;
    int                        cycle_count = 0;
    int                        stall_pct;

    // Opcode maps written between phases, extremes included.
    logic [fae_pkg::MAP_W-1:0] phase_maps [6];

    four_register_alu_executor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    four_register_alu_executor_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_expected_count (expected_count)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Result side stalls at random.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("four_register_alu_executor_tb NOT OK");
            $finish;
        end
    end

    // Offers one instruction item after an optional random gap and waits for acceptance.
    task automatic send_instr(fae_pkg::t_in_item instr);
        while ($urandom_range(99) < stall_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= instr;
        do @(posedge clk); while (!in_ready);
    endtask

    // Sends one instruction by operation name; the identity map must be active.
    task automatic send_op(fae_pkg::t_alu_op op, logic [IMM_W-1:0] a, logic [IMM_W-1:0] b,
                           logic [DEST_W-1:0] dest);
        fae_pkg::t_in_item instr;
        instr.raw_opcode = op;
        instr.operand_a  = a;
        instr.operand_b  = b;
        instr.dest_index = dest;
        send_instr(instr);
    endtask

    // Holds off the sender until every expected result item has arrived.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_count != 0) @(posedge clk);
    endtask

    task automatic write_map(logic [fae_pkg::MAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small register indices, sometimes full-range or extreme operands.
    function automatic logic [IMM_W-1:0] rand_operand();
        case ($urandom_range(7))
            0, 1:    return IMM_W'($urandom_range(65535));
            2:       return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
            default: return IMM_W'($urandom_range(3));
        endcase
    endfunction

    function automatic fae_pkg::t_in_item rand_instr();
        fae_pkg::t_in_item instr;
        instr.raw_opcode = OPC_W'($urandom_range(15));
        instr.operand_a  = rand_operand();
        instr.operand_b  = rand_operand();
        instr.dest_index = DEST_W'($urandom_range(3));
        return instr;
    endfunction

    initial begin
        stall_pct   = 8;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;

        phase_maps[0] = {$urandom, $urandom};
        phase_maps[1] = 64'h0;
        phase_maps[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_maps[3] = 64'h0123_4567_89AB_CDEF;
        phase_maps[4] = {$urandom, $urandom};
        phase_maps[5] = fae_pkg::MAP_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the identity map: large values, wraparound, index folding,
        // full-width immediate comparisons and both outcomes of GTIR, EQRI and EQRR.
        send_op(fae_pkg::OP_SETI, 16'hFFFF, 16'hFFFF, 2'd0);
        send_op(fae_pkg::OP_SETI, 16'h0000, 16'h0000, 2'd3);
        send_op(fae_pkg::OP_MULR, 16'd0, 16'hFFFC, 2'd1);
        send_op(fae_pkg::OP_MULR, 16'd1, 16'd5, 2'd1);
        send_op(fae_pkg::OP_MULR, 16'd1, 16'd1, 2'd2);
        send_op(fae_pkg::OP_ADDR, 16'd2, 16'd2, 2'd2);
        send_op(fae_pkg::OP_ADDI, 16'd2, 16'hFFFF, 2'd3);
        send_op(fae_pkg::OP_MULI, 16'd3, 16'hFFFF, 2'd3);
        send_op(fae_pkg::OP_BANR, 16'd1, 16'd2, 2'd0);
        send_op(fae_pkg::OP_BANI, 16'd2, 16'hFFFF, 2'd1);
        send_op(fae_pkg::OP_BORR, 16'd0, 16'd3, 2'd2);
        send_op(fae_pkg::OP_BORI, 16'd4, 16'h8000, 2'd3);
        send_op(fae_pkg::OP_SETR, 16'hFFFE, 16'd0, 2'd0);
        send_op(fae_pkg::OP_SETI, 16'd1234, 16'd0, 2'd1);
        send_op(fae_pkg::OP_GTIR, 16'hFFFF, 16'd1, 2'd2);
        send_op(fae_pkg::OP_GTIR, 16'd0, 16'd1, 2'd2);
        send_op(fae_pkg::OP_GTRI, 16'd1, 16'd1233, 2'd3);
        send_op(fae_pkg::OP_GTRI, 16'd0, 16'hFFFF, 2'd3);
        send_op(fae_pkg::OP_GTRR, 16'd1, 16'd0, 2'd2);
        send_op(fae_pkg::OP_EQIR, 16'd1234, 16'd1, 2'd0);
        send_op(fae_pkg::OP_EQRI, 16'd1, 16'd1234, 2'd3);
        send_op(fae_pkg::OP_EQRI, 16'd1, 16'd1235, 2'd3);
        send_op(fae_pkg::OP_EQRR, 16'd7, 16'd3, 2'd2);
        send_op(fae_pkg::OP_EQRR, 16'd1, 16'd0, 2'd2);
        drain();

        // Random phases, each under its own opcode map; one phase runs with no stalls.
        for (int p = 0; p < 6; p++) begin
            write_map(phase_maps[p]);
            stall_pct = (p == 2) ? 0 : 8;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_instr(rand_instr());
            end
            drain();
        end

        stall_pct = 8;
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("four_register_alu_executor_tb OK");
        end else begin
            $display("four_register_alu_executor_tb NOT OK");
        end
        $finish;
    end

endmodule
